// File: rtl/core/prf_pkg.sv
// Shared types, constants and the header byte table for the pcap radiotap framer.
// Depends on nothing; the front end, queue, emitter and top level import it.
package prf_pkg;

  localparam int POS_W = 6;

  // Byte positions inside the longest header burst (global, record, radiotap, signal, payload).
  localparam logic [POS_W-1:0] POS_GLOBAL   = 6'd0;
  localparam logic [POS_W-1:0] POS_RECORD   = 6'd24;
  localparam logic [POS_W-1:0] POS_RADIOTAP = 6'd40;
  localparam logic [POS_W-1:0] POS_SIGNAL   = 6'd54;
  localparam logic [POS_W-1:0] POS_PAYLOAD  = 6'd55;

  localparam logic [31:0] PCAP_MAGIC      = 32'hA1B2C3D4;
  localparam logic [7:0]  PCAP_VER_MAJOR  = 8'd2;
  localparam logic [7:0]  PCAP_VER_MINOR  = 8'd4;
  localparam logic [7:0]  LINKTYPE_RT     = 8'd127;
  localparam logic [7:0]  RT_HDR_LEN      = 8'd15;
  localparam logic [7:0]  RT_PRESENT      = 8'h2A;
  localparam logic [15:0] RT_CHAN_FLAGS   = 16'h0080;
  localparam logic [7:0]  RT_FLAG_FCS     = 8'h10;
  localparam logic [7:0]  CH_JAPAN        = 8'd14;
  localparam logic [11:0] FREQ_CH_JAPAN   = 12'd2484;
  localparam logic [11:0] FREQ_BASE       = 12'd2407;

  localparam logic [19:0] USEC_PER_SEC    = 20'd1000000;
  // The timestamp is divided as four 16-bit digits, each with a step that forms it and a step that shifts.
  localparam int          DIV_STEPS       = 8;
  // ceil(2^44 / 15625): exact quotient by 15625 for any 30-bit dividend after >> 44.
  localparam logic [30:0] USEC_RECIP      = 31'd1125899907;
  localparam int          USEC_RECIP_SHIFT = 44;

  localparam logic [15:0] SNAP_RESET      = 16'hFFFF;
  localparam logic        REG_SNAP_LENGTH = 1'b0;

  // One queue entry: a payload byte, a frame start with its metadata, or both.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        first;
    logic        global_hdr;
    logic [31:0] sec;
    logic [19:0] usec;
    logic [15:0] cap;
    logic [15:0] orig;
    logic [11:0] freq;
    logic        fcs;
    logic [7:0]  sig;
  } desc_t;

  function automatic logic [7:0] hdr_byte(input logic [POS_W-1:0] pos,
                                          input logic [15:0] snap,
                                          input desc_t d);
    logic [31:0] snap15;
    logic [31:0] cap15;
    logic [31:0] orig15;
    logic [31:0] usec32;
    logic [7:0]  b;
    snap15 = {15'd0, {1'b0, snap} + 17'd15};
    cap15  = {15'd0, {1'b0, d.cap} + 17'd15};
    orig15 = {15'd0, {1'b0, d.orig} + 17'd15};
    usec32 = {12'd0, d.usec};
    b = 8'd0;
    unique case (pos)
      6'd0:  b = PCAP_MAGIC[7:0];
      6'd1:  b = PCAP_MAGIC[15:8];
      6'd2:  b = PCAP_MAGIC[23:16];
      6'd3:  b = PCAP_MAGIC[31:24];
      6'd4:  b = PCAP_VER_MAJOR;
      6'd6:  b = PCAP_VER_MINOR;
      6'd16: b = snap15[7:0];
      6'd17: b = snap15[15:8];
      6'd18: b = snap15[23:16];
      6'd19: b = snap15[31:24];
      6'd20: b = LINKTYPE_RT;
      6'd24: b = d.sec[7:0];
      6'd25: b = d.sec[15:8];
      6'd26: b = d.sec[23:16];
      6'd27: b = d.sec[31:24];
      6'd28: b = usec32[7:0];
      6'd29: b = usec32[15:8];
      6'd30: b = usec32[23:16];
      6'd31: b = usec32[31:24];
      6'd32: b = cap15[7:0];
      6'd33: b = cap15[15:8];
      6'd34: b = cap15[23:16];
      6'd35: b = cap15[31:24];
      6'd36: b = orig15[7:0];
      6'd37: b = orig15[15:8];
      6'd38: b = orig15[23:16];
      6'd39: b = orig15[31:24];
      6'd42: b = RT_HDR_LEN;
      6'd44: b = RT_PRESENT;
      6'd48: b = d.fcs ? RT_FLAG_FCS : 8'd0;
      6'd50: b = d.freq[7:0];
      6'd51: b = {4'd0, d.freq[11:8]};
      6'd52: b = RT_CHAN_FLAGS[7:0];
      6'd53: b = RT_CHAN_FLAGS[15:8];
      6'd54: b = d.sig;
      6'd55: b = d.payload_byte;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/prf_if.sv
// Valid/ready channel interfaces of the pcap radiotap framer: frame input and byte output.
// Depends on nothing.
interface prf_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        payload_byte;
  logic              payload_valid;
  logic              first_of_frame;
  logic              last_of_frame;
  logic [63:0]       time_us;
  logic [15:0]       captured_bytes;
  logic [15:0]       original_bytes;
  logic [7:0]        channel_number;
  logic signed [7:0] signal_dbm;
  logic              fcs_present;

  modport source (output valid, payload_byte, payload_valid, first_of_frame, last_of_frame,
                  time_us, captured_bytes, original_bytes, channel_number, signal_dbm,
                  fcs_present, input ready);
  modport sink (input valid, payload_byte, payload_valid, first_of_frame, last_of_frame,
                time_us, captured_bytes, original_bytes, channel_number, signal_dbm,
                fcs_present, output ready);
endinterface

interface prf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_header;
  logic       run_last;

  modport source (output valid, out_byte, is_header, run_last, input ready);
  modport sink (input valid, out_byte, is_header, run_last, output ready);
endinterface

// File: rtl/core/prf_front.sv
// Front end: accepts input items, builds queue entries and divides the timestamp.
// Depends on prf_pkg and prf_in_if.
module prf_front (
  input  logic            clk,
  input  logic            rst,
  prf_in_if.sink          frame,
  input  logic            full,
  output logic            push,
  output prf_pkg::desc_t  push_data
);
  import prf_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic              global_done;
  logic [63:0]       dividend;
  logic [19:0]       rem;
  logic [15:0]       qdig;
  logic [31:0]       quo;
  desc_t             hold;

  logic              accept;
  logic              div_done;
  logic [35:0]       num;
  logic [60:0]       prod;
  logic [35:0]       qmul;
  logic [35:0]       rem_full;
  logic [11:0]       freq;

  assign frame.ready = !busy && !full;
  assign accept      = frame.valid && frame.ready;
  assign div_done    = busy && (cnt == CNT_W'(DIV_STEPS));

  assign freq = (frame.channel_number == CH_JAPAN) ? FREQ_CH_JAPAN :
                FREQ_BASE + {2'd0, frame.channel_number, 2'd0} + {4'd0, frame.channel_number};

  // Long division by one million in 16-bit digits. The partial numerator is below
  // 1e6 * 2^16, so dropping its six low bits leaves a 30-bit value whose quotient by
  // 15625 comes exactly from the reciprocal product. Even steps form the digit, odd
  // steps take the remainder back and shift in the next digit of the timestamp.
  assign num      = {rem, dividend[63:48]};
  assign prod     = {31'd0, num[35:6]} * {30'd0, USEC_RECIP};
  assign qmul     = {20'd0, qdig} * {16'd0, USEC_PER_SEC};
  assign rem_full = num - qmul;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cnt         <= '0;
      global_done <= 1'b0;
    end else if (accept && frame.first_of_frame) begin
      busy        <= 1'b1;
      cnt         <= '0;
      global_done <= 1'b1;
    end else if (busy && !div_done) begin
      cnt <= cnt + CNT_W'(1);
    end else if (div_done && !full) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame.first_of_frame) begin
      dividend           <= frame.time_us;
      rem                <= '0;
      qdig               <= '0;
      quo                <= '0;
      hold.payload_byte  <= frame.payload_byte;
      hold.payload_valid <= frame.payload_valid;
      hold.first         <= 1'b1;
      hold.global_hdr    <= !global_done;
      hold.sec           <= '0;
      hold.usec          <= '0;
      hold.cap           <= frame.captured_bytes;
      hold.orig          <= frame.original_bytes;
      hold.freq          <= freq;
      hold.fcs           <= frame.fcs_present;
      hold.sig           <= frame.signal_dbm;
    end else if (busy && !div_done) begin
      if (!cnt[0]) begin
        qdig <= prod[USEC_RECIP_SHIFT +: 16];
      end else begin
        rem      <= rem_full[19:0];
        quo      <= {quo[15:0], qdig};
        dividend <= dividend << 16;
      end
    end
  end

  assign push = div_done ? !full
                         : (accept && !frame.first_of_frame && frame.payload_valid);

  always_comb begin
    push_data = '0;
    if (busy) begin
      push_data      = hold;
      push_data.sec  = quo;
      push_data.usec = rem;
    end else begin
      push_data.payload_byte  = frame.payload_byte;
      push_data.payload_valid = 1'b1;
    end
  end

endmodule

// File: rtl/core/prf_queue.sv
// Short entry queue between the front end and the byte emitter.
// Depends on prf_pkg.
module prf_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  prf_pkg::desc_t  push_data,
  output logic            full,
  input  logic            pop,
  output prf_pkg::desc_t  pop_data,
  output logic            empty
);
  import prf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count did not follow a write");

endmodule

// File: rtl/core/prf_back.sv
// Back end: walks each queue entry byte by byte into the registered output channel.
// Depends on prf_pkg and prf_out_if.
module prf_back (
  input  logic            clk,
  input  logic            rst,
  input  prf_pkg::desc_t  head,
  input  logic            empty,
  input  logic [15:0]     snap_length,
  output logic            pop,
  prf_out_if.source       stream
);
  import prf_pkg::*;

  logic             started;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_cur;
  logic [POS_W-1:0] pos_end;
  logic             load;

  // A new entry starts at the global, record or payload position.
  always_comb begin
    if (started) begin
      pos_cur = pos;
    end else if (head.first) begin
      pos_cur = head.global_hdr ? POS_GLOBAL : POS_RECORD;
    end else begin
      pos_cur = POS_PAYLOAD;
    end
    pos_end = head.payload_valid ? POS_PAYLOAD : POS_SIGNAL;
  end

  assign load = !empty && (!stream.valid || stream.ready);
  assign pop  = load && (pos_cur == pos_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      stream.valid <= 1'b0;
    end else begin
      if (load) begin
        stream.valid <= 1'b1;
        started      <= !pop;
      end else if (stream.ready) begin
        stream.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos              <= pos_cur + POS_W'(1);
      stream.out_byte  <= hdr_byte(pos_cur, snap_length, head);
      stream.is_header <= (pos_cur != POS_PAYLOAD);
      stream.run_last  <= (pos_cur == pos_end);
    end
  end

endmodule

// File: rtl/core/pcap_radiotap_framer.sv
// Top level of the pcap radiotap framer: configuration register, front end, queue, emitter.
// Depends on prf_pkg, prf_if, prf_front, prf_queue and prf_back.
//
//   Channel   Direction  Handshake              Carries
//   frame     in         valid/ready            one captured byte plus frame metadata
//   stream    out        valid/ready            one pcap stream byte, header flag, run end
//   APB       in         psel/penable/pready    snap_length at byte address 0
//
// A payload-only item passes through the queue and the output register, and a payload
// stream passes at one byte per cycle unless the queue fills or the output stalls. A
// first-of-frame item holds the front end while the timestamp is divided by one million,
// one 16-bit quotient digit at a time by reciprocal multiplication; the emitter then
// sends the record and radiotap headers (the global header first for the very first
// frame) plus any payload byte, so header bursts are output-bound. Reset is synchronous
// and clears only control state. Both sides stall independently through the queue.
module pcap_radiotap_framer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  prf_in_if.sink       frame,
  prf_out_if.source    stream,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import prf_pkg::*;

  logic [15:0] snap_length;
  logic        cfg_hit;
  desc_t       push_data;
  desc_t       head;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;

  // The single register decodes on the word index above the byte offset.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == REG_SNAP_LENGTH);
  assign prdata  = cfg_hit ? {16'd0, snap_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_length <= SNAP_RESET;
    end else if (psel && penable && pwrite && cfg_hit) begin
      snap_length <= pwdata[15:0];
    end
  end

  // The front end classifies items and resolves timestamps ahead of the emitter.
  prf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  prf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  // The emitter owns the output register; the snap length is read while a global header
  // goes out, so configuration must only change when idle, which the block does not enforce.
  prf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .snap_length (snap_length),
    .pop         (pop),
    .stream      (stream)
  );

endmodule
